@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define JWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define JWS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/jws_pkg.sv @@
// types and constants of the jaro-winkler similarity core
package jws_pkg;

  localparam int CHAR_W    = 8;
  localparam int SIM_W     = 17;
  localparam int CNT_W     = 7;
  localparam int PFX_W     = 4;
  localparam int WGT_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int DIV_STEPS = 18;
  localparam int PFX_CELLS = 15;

  localparam logic [SIM_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0]      HALF_LSB = 16'h8000;

  localparam logic [WGT_W-1:0]  PW_RESET   = 15'd6554;
  localparam logic [PFX_W-1:0]  PL_RESET   = 4'd4;
  localparam logic [CHAR_W-1:0] BCH_RESET  = 8'd47;
  localparam logic [WGT_W-1:0]  BW_RESET   = 15'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREFIX_WEIGHT = 2'd0,
    CFG_PREFIX_LIMIT  = 2'd1,
    CFG_BONUS_CHAR    = 2'd2,
    CFG_BONUS_WEIGHT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLEAR,
    S_ROT,
    S_PAIR,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_DIV,
    S_BOOST1,
    S_BOOST2,
    S_BONUS,
    S_DONE
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic clear;
    logic rotate;
    logic shift_a;
    logic shift_b;
  } cell_ctl_t;

endpackage

@@ rtl/jws_if.sv @@
// valid/ready channels for character items and scores
interface jws_in_if import jws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              string_sel;
  logic [CHAR_W-1:0] char_code;
  logic              char_valid;
  logic              end_of_pair;

  modport source (output valid, string_sel, char_code, char_valid, end_of_pair,
                  input ready);
  modport sink   (input valid, string_sel, char_code, char_valid, end_of_pair,
                  output ready);
endinterface

interface jws_out_if import jws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SIM_W-1:0] similarity;
  logic [CNT_W-1:0] match_count;
  logic [PFX_W-1:0] prefix_length;

  modport source (output valid, similarity, match_count, prefix_length, input ready);
  modport sink   (input valid, similarity, match_count, prefix_length, output ready);
endinterface

@@ rtl/jws_cell.sv @@
// one cell: a byte of each string, its match flag and the ring position of its b byte
module jws_cell import jws_pkg::*; #(
  parameter int MAX_LEN = 64,
  parameter int IDX     = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] code,
  input  logic [$clog2(MAX_LEN+1)-1:0] l1,
  input  logic [$clog2(MAX_LEN+1)-1:0] l2,
  input  logic [$clog2(MAX_LEN+1)-1:0] half,
  input  logic [CHAR_W-1:0] a_in,
  input  logic              a_flag_in,
  input  logic [CHAR_W-1:0] b_in,
  input  logic              b_flag_in,
  input  logic [$clog2(MAX_LEN)-1:0] b_idx_in,
  output logic [CHAR_W-1:0] a_out,
  output logic              a_flag_out,
  output logic [CHAR_W-1:0] b_out,
  output logic              b_flag_out,
  output logic [$clog2(MAX_LEN)-1:0] b_idx_out,
  output logic              eq
);

  localparam int LW = $clog2(MAX_LEN+1);
  localparam int IW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] MY_POS = LW'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [CHAR_W-1:0] a_byte, b_byte;
  logic              a_flag, b_flag;
  logic [IW-1:0]     b_idx;
  logic [IW-1:0]     sep;
  logic              hit;

  assign sep = (b_idx > MY_IDX) ? (b_idx - MY_IDX) : (MY_IDX - b_idx);
  assign hit  = ctl.rotate && (MY_POS < l1) && (LW'(b_idx) < l2) &&
                (a_byte == b_byte) && (LW'(sep) < half);

  assign a_out      = a_byte;
  assign a_flag_out = a_flag;
  assign b_out      = b_byte;
  assign b_flag_out = b_flag | hit;
  assign b_idx_out  = b_idx;
  assign eq         = (a_byte == b_byte);

  always_ff @(posedge clk) begin
    if (ctl.wr_a && (l1 == MY_POS)) begin
      a_byte <= code;
    end else if (ctl.shift_a) begin
      a_byte <= a_in;
    end

    if (ctl.clear) begin
      a_flag <= 1'b0;
    end else if (ctl.rotate) begin
      a_flag <= a_flag | hit;
    end else if (ctl.shift_a) begin
      a_flag <= a_flag_in;
    end

    if (ctl.wr_b && (l2 == MY_POS)) begin
      b_byte <= code;
    end else if (ctl.rotate || ctl.shift_b) begin
      b_byte <= b_in;
    end

    if (ctl.clear) begin
      b_flag <= 1'b0;
    end else if (ctl.rotate || ctl.shift_b) begin
      b_flag <= b_flag_in;
    end

    if (ctl.clear) begin
      b_idx <= MY_IDX;
    end else if (ctl.rotate) begin
      b_idx <= b_idx_in;
    end
  end

endmodule

@@ rtl/jaro_winkler_similarity_core.sv @@
// Jaro-Winkler similarity core: bytes load one per cycle (string_sel picks the
// string, a byte past MAX_LEN is dropped); the item with end_of_pair starts
// scoring and the input stalls until the score sits in the output register.
// Scoring runs on a ring of MAX_LEN cells: the second string rotates past the
// first to mark matches, both strings pop out of cell 0 to pair matched bytes,
// then come the multiply steps, a setup step, a restoring divider and the boost
// and bonus steps; a pair with too few matches skips from pairing to the result.
// The result register frees the core while the score waits to be taken.
module jaro_winkler_similarity_core import jws_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  jws_in_if.sink               in_ch,
  jws_out_if.source            out_ch
);

  localparam int LW = $clog2(MAX_LEN+1);
  localparam int IW = $clog2(MAX_LEN);
  localparam int NW = 3*LW + 3;
  localparam int XW = NW + DIV_STEPS;
  localparam int PC = (MAX_LEN < PFX_CELLS) ? MAX_LEN : PFX_CELLS;
  localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

  state_t state, state_next;
  cell_ctl_t ctl;

  // configuration registers
  logic [WGT_W-1:0]  pw, bw;
  logic [PFX_W-1:0]  plim;
  logic [CHAR_W-1:0] bch;

  logic [LW-1:0] l1, l2, lmin, lmax, half;

  // cell ring
  logic [CHAR_W-1:0] a_out [MAX_LEN];
  logic [CHAR_W-1:0] b_out [MAX_LEN];
  logic [MAX_LEN-1:0] a_flag, b_flag, eq;
  logic [IW-1:0] b_idx [MAX_LEN];

  // scoring registers
  logic [LW-1:0] rot_cnt, a_pos, b_pos, m, t, bc;
  logic [PFX_W-1:0] pre, pre_c;
  logic zero;
  logic [2*LW-1:0] mm, ll;
  logic [LW:0] tm, sum_l;
  logic [3*LW:0] p1, p2;
  logic [3*LW-1:0] den;
  logic [NW-1:0] num, den6;
  logic [XW-1:0] x_c;
  logic [NW:0] rem, dsr;
  logic [NW+1:0] r2;
  logic [DIV_STEPS-1:0] xlo, q;
  logic [4:0] div_cnt;
  logic [SIM_W-1:0] jq, wq, sq;
  logic [PFX_W+WGT_W-1:0] p_pw;
  logic [LW+WGT_W-1:0] bc_bw;
  logic [PFX_W+WGT_W+SIM_W-1:0] boost_prod;
  logic [LW+WGT_W+SIM_W-1:0] bonus_prod;
  logic [PFX_W+WGT_W+SIM_W:0] w_sum;
  logic [LW+WGT_W+SIM_W:0] s_sum;

  logic out_valid;
  logic in_xfer, out_free;
  logic a_done, b_done, a_m, b_m, pop_a, pop_b, zero_c;

  assign lmin = (l1 < l2) ? l1 : l2;
  assign lmax = (l1 < l2) ? l2 : l1;
  assign half = lmax >> 1;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // pairing: heads of both rings sit in cell 0
  assign a_done = (a_pos == FULL);
  assign b_done = (b_pos == FULL);
  assign a_m    = !a_done && a_flag[0];
  assign b_m    = !b_done && b_flag[0];
  assign zero_c = (m == '0) || ({m, 1'b0} < {1'b0, lmin});

  // ring of cells, each takes its neighbor's bytes on a shift
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_LEN;
    jws_cell #(.MAX_LEN(MAX_LEN), .IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .code       (in_ch.char_code),
      .l1         (l1),
      .l2         (l2),
      .half       (half),
      .a_in       (a_out[NB]),
      .a_flag_in  (a_flag[NB]),
      .b_in       (b_out[NB]),
      .b_flag_in  (b_flag[NB]),
      .b_idx_in   (b_idx[NB]),
      .a_out      (a_out[i]),
      .a_flag_out (a_flag[i]),
      .b_out      (b_out[i]),
      .b_flag_out (b_flag[i]),
      .b_idx_out  (b_idx[i]),
      .eq         (eq[i])
    );
  end

  // common prefix over the first few cells, strings still aligned
  always_comb begin
    logic [PFX_CELLS-1:0] eq_lo;
    logic run;
    eq_lo = PFX_CELLS'(eq[PC-1:0]);
    run   = 1'b1;
    pre_c = '0;
    for (int k = 0; k < PFX_CELLS; k++) begin
      if (run && eq_lo[k] && (k < int'(plim)) && (k < int'(lmin))) begin
        pre_c = pre_c + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
  end

  // divider datapath: dividend is num * 2^17 plus den6 for rounding
  assign x_c = {1'b0, num, {(DIV_STEPS-1){1'b0}}} + XW'(den6);
  assign r2  = {rem, xlo[DIV_STEPS-1]};

  // boost and bonus products
  assign boost_prod = p_pw * (ONE_Q16 - jq);
  assign bonus_prod = bc_bw * (ONE_Q16 - wq);
  assign w_sum = (PFX_W+WGT_W+SIM_W+1)'(jq) +
                 (PFX_W+WGT_W+SIM_W+1)'((boost_prod + HALF_LSB) >> 16);
  assign s_sum = (LW+WGT_W+SIM_W+1)'(wq) +
                 (LW+WGT_W+SIM_W+1)'((bonus_prod + HALF_LSB) >> 16);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (in_xfer && in_ch.end_of_pair) state_next = S_CLEAR;
      S_CLEAR:  state_next = S_ROT;
      S_ROT:    if (rot_cnt == LW'(MAX_LEN-1)) state_next = S_PAIR;
      S_PAIR: begin
        if (a_done && b_done) state_next = zero_c ? S_DONE : S_MUL1;
      end
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_MUL3;
      S_MUL3:   state_next = S_PREP;
      S_PREP:   state_next = S_DIV;
      S_DIV:    if (div_cnt == 5'(DIV_STEPS-1)) state_next = S_BOOST1;
      S_BOOST1: state_next = S_BOOST2;
      S_BOOST2: state_next = S_BONUS;
      S_BONUS:  state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    pop_a       = 1'b0;
    pop_b       = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ch.ready = 1'b1;
        ctl.wr_a = in_ch.valid && in_ch.char_valid && !in_ch.string_sel && (l1 < FULL);
        ctl.wr_b = in_ch.valid && in_ch.char_valid && in_ch.string_sel && (l2 < FULL);
      end
      S_CLEAR: ctl.clear  = 1'b1;
      S_ROT:   ctl.rotate = 1'b1;
      S_PAIR: begin
        // a matched head waits for the other side's next matched byte
        pop_a = !a_done && (!a_m || b_m || b_done);
        pop_b = !b_done && (!b_m || a_m || a_done);
        ctl.shift_a = pop_a;
        ctl.shift_b = pop_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pw   <= PW_RESET;
      plim <= PL_RESET;
      bch  <= BCH_RESET;
      bw   <= BW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PREFIX_WEIGHT: pw   <= cfg_data[WGT_W-1:0];
        CFG_PREFIX_LIMIT:  plim <= cfg_data[PFX_W-1:0];
        CFG_BONUS_CHAR:    bch  <= cfg_data[CHAR_W-1:0];
        CFG_BONUS_WEIGHT:  bw   <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // string lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= '0;
      l2 <= '0;
    end else if (state == S_DONE && out_free) begin
      l1 <= '0;
      l2 <= '0;
    end else begin
      if (ctl.wr_a) l1 <= l1 + 1'b1;
      if (ctl.wr_b) l2 <= l2 + 1'b1;
    end
  end

  // scoring datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_CLEAR: begin
        rot_cnt <= '0;
        a_pos   <= '0;
        b_pos   <= '0;
        m       <= '0;
        t       <= '0;
        bc      <= '0;
        pre     <= pre_c;
      end
      S_ROT: rot_cnt <= rot_cnt + 1'b1;
      S_PAIR: begin
        zero <= zero_c;
        if (pop_a) a_pos <= a_pos + 1'b1;
        if (pop_b) b_pos <= b_pos + 1'b1;
        if (a_m && pop_a && (a_out[0] == bch)) bc <= bc + 1'b1;
        if (a_m && b_m) begin
          m <= m + 1'b1;
          if (a_out[0] != b_out[0]) t <= t + 1'b1;
        end
      end
      S_MUL1: begin
        mm    <= m * m;
        ll    <= l1 * l2;
        tm    <= {m, 1'b0} - (LW+1)'(t);
        sum_l <= (LW+1)'(l1) + (LW+1)'(l2);
      end
      S_MUL2: begin
        p1  <= mm * sum_l;
        p2  <= (3*LW+1)'(tm) * (3*LW+1)'(ll);
        den <= m * ll;
      end
      S_MUL3: begin
        num  <= (NW'(p1) << 1) + NW'(p2);
        den6 <= (NW'(den) << 2) + (NW'(den) << 1);
      end
      S_PREP: begin
        rem     <= (NW+1)'(x_c >> DIV_STEPS);
        xlo     <= x_c[DIV_STEPS-1:0];
        dsr     <= {den6, 1'b0};
        div_cnt <= '0;
      end
      S_DIV: begin
        if (r2 >= {1'b0, dsr}) begin
          rem <= (NW+1)'(r2 - {1'b0, dsr});
          q   <= {q[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem <= r2[NW:0];
          q   <= {q[DIV_STEPS-2:0], 1'b0};
        end
        xlo     <= {xlo[DIV_STEPS-2:0], 1'b0};
        div_cnt <= div_cnt + 1'b1;
      end
      S_BOOST1: begin
        jq    <= (q > DIV_STEPS'(ONE_Q16)) ? ONE_Q16 : q[SIM_W-1:0];
        p_pw  <= pre * pw;
        bc_bw <= bc * bw;
      end
      S_BOOST2: begin
        wq <= (w_sum > (PFX_W+WGT_W+SIM_W+1)'(ONE_Q16)) ? ONE_Q16 : w_sum[SIM_W-1:0];
      end
      S_BONUS: begin
        sq <= (s_sum > (LW+WGT_W+SIM_W+1)'(ONE_Q16)) ? ONE_Q16 : s_sum[SIM_W-1:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.similarity    <= zero ? '0 : sq;
      out_ch.match_count   <= CNT_W'(m);
      out_ch.prefix_length <= zero ? '0 : pre;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

@@ rtl/jws_checker.sv @@
// port-level checks of the similarity core, bound to its top level
`include "assert_macros.svh"

module jws_checker import jws_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_end_of_pair,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SIM_W-1:0] out_similarity
);

  // a waiting score stays offered
  `JWS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "score dropped before transfer")

  // closing a pair stalls the input while it is scored
  `JWS_ASSERT(a_stall_after_pair, in_valid && in_ready && in_end_of_pair |=> !in_ready, "input taken during scoring")

  // score saturates at one
  `JWS_NEVER(a_sim_range, out_valid && (out_similarity > ONE_Q16), "score above one")

endmodule

bind jaro_winkler_similarity_core jws_checker u_jws_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_end_of_pair (in_ch.end_of_pair),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_similarity (out_ch.similarity)
);

@@ tb/jaro_winkler_similarity_core_test.sv @@
// testbench for the jaro-winkler similarity core: random char streams, scored against a local model
`timescale 1ns / 100ps
module jaro_winkler_similarity_core_test;
  import jws_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PAIRS = 100;

  // one character transfer
  typedef struct packed {
    logic             string_sel;
    logic [CHAR_W-1:0] char_code;
    logic             char_valid;
    logic             end_of_pair;
  } char_item_t;

  // one score transfer
  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [CNT_W-1:0] match_count;
    logic [PFX_W-1:0] prefix_length;
  } score_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  jws_in_if  in_ch ();
  jws_out_if out_ch ();

  jaro_winkler_similarity_core #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // shadow of the core's state and registers
  logic [CHAR_W-1:0] str_a [MAX_LEN];
  logic [CHAR_W-1:0] str_b [MAX_LEN];
  int unsigned len_a, len_b;
  logic [WGT_W-1:0]  pw;
  logic [PFX_W-1:0]  plim_reg;
  logic [CHAR_W-1:0] bchar;
  logic [WGT_W-1:0]  bw;

  char_item_t pending_chars[$];
  score_t     expected_scores[$];

  int  errors = 0;
  int  scores_seen = 0;
  int  chars_sent = 0;
  int  idle_cycles = 0;
  bit  long_hold = 0;     // receiver holds off for a long stretch
  bit  done_driving = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // collect matches of one side against the other, in order
  function automatic int unsigned match_side(input bit a_side, input int unsigned lmax,
                                             output logic [CHAR_W-1:0] lst [MAX_LEN],
                                             output int unsigned bonus);
    int unsigned n, la, lb, d;
    logic [CHAR_W-1:0] ca, cb;
    n = 0;
    bonus = 0;
    la = a_side ? len_a : len_b;
    lb = a_side ? len_b : len_a;
    for (int i = 0; i < la; i++) begin
      for (int j = 0; j < lb; j++) begin
        ca = a_side ? str_a[i] : str_b[i];
        cb = a_side ? str_b[j] : str_a[j];
        d = (i > j) ? i - j : j - i;
        if (2 * d + 2 <= lmax && ca == cb) begin
          if (ca == bchar) bonus++;
          lst[n] = ca;
          n++;
          break;
        end
      end
    end
    return n;
  endfunction

  // score the buffered pair the way the core should
  function automatic score_t score_buffers();
    score_t r;
    logic [CHAR_W-1:0] la_list [MAX_LEN];
    logic [CHAR_W-1:0] lb_list [MAX_LEN];
    int unsigned lmax, lmin, n1, n2, m, bcnt, dummy, pre, lim, t;
    longint unsigned num, den, jq, wq, sq;
    lmax = (len_a > len_b) ? len_a : len_b;
    lmin = (len_a < len_b) ? len_a : len_b;
    n1 = match_side(1, lmax, la_list, bcnt);
    n2 = match_side(0, lmax, lb_list, dummy);
    m = (n1 < n2) ? n1 : n2;
    r = '0;
    r.match_count = m[CNT_W-1:0];
    if (m == 0 || 2 * m < lmin) return r;
    lim = (plim_reg < lmin) ? plim_reg : lmin;
    pre = 0;
    while (pre < lim && str_a[pre] == str_b[pre]) pre++;
    t = 0;
    for (int k = 0; k < m; k++) if (la_list[k] != lb_list[k]) t++;
    num = 2 * longint'(m) * m * len_b + 2 * longint'(m) * m * len_a
        + longint'(2 * m - t) * len_a * len_b;
    den = 6 * longint'(m) * len_a * len_b;
    jq = (num * 65536 * 2 + den) / (2 * den);
    if (jq > 65536) jq = 65536;
    wq = jq + ((longint'(pre) * pw * (65536 - jq) + 32768) >> 16);
    if (wq > 65536) wq = 65536;
    sq = wq + ((longint'(bcnt) * bw * (65536 - wq) + 32768) >> 16);
    if (sq > 65536) sq = 65536;
    r.similarity = sq[SIM_W-1:0];
    r.prefix_length = pre[PFX_W-1:0];
    return r;
  endfunction

  // advance the shadow by one accepted char transfer
  function automatic void absorb_char(input char_item_t it);
    if (it.char_valid) begin
      if (!it.string_sel) begin
        if (len_a < MAX_LEN) begin str_a[len_a] = it.char_code; len_a++; end
      end else begin
        if (len_b < MAX_LEN) begin str_b[len_b] = it.char_code; len_b++; end
      end
    end
    if (it.end_of_pair) begin
      expected_scores.push_back(score_buffers());
      len_a = 0;
      len_b = 0;
    end
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // driver: offers queued chars, with random gaps while gaps_on is set
  int unsigned send_gap = 0;
  bit gaps_on = 1;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_char(pending_chars.pop_front());
        chars_sent++;
        send_gap = gaps_on ? gap_len() : 0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 0;
        end else if (pending_chars.size() > 0) begin
          in_ch.valid <= 1;
          {in_ch.string_sel, in_ch.char_code, in_ch.char_valid, in_ch.end_of_pair}
            <= pending_chars[0];
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor: back-pressure (random, a long hold-off, or none) and score checks
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    score_t got, want;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.similarity, out_ch.match_count, out_ch.prefix_length};
        scores_seen++;
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected score %h", $time, got);
          errors++;
        end else begin
          want = expected_scores.pop_front();
          if (got.similarity !== want.similarity) begin
            $display("%0t: similarity expected %0d actual %0d", $time,
                     want.similarity, got.similarity);
            errors++;
          end
          if (got.match_count !== want.match_count) begin
            $display("%0t: match_count expected %0d actual %0d", $time,
                     want.match_count, got.match_count);
            errors++;
          end
          if (got.prefix_length !== want.prefix_length) begin
            $display("%0t: prefix_length expected %0d actual %0d", $time,
                     want.prefix_length, got.prefix_length);
            errors++;
          end
        end
      end
      // long hold-off so results back up and the input stalls
      if (long_hold) begin
        if (hold_cnt < 2000) begin
          hold_cnt++;
          out_ch.ready <= 0;
        end else begin
          out_ch.ready <= 1;
        end
      end else if (!gaps_on) begin
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("jaro_winkler_similarity_core_test: FAIL");
        $finish;
      end
    end
  end

  task automatic push_char(input bit sel, input logic [CHAR_W-1:0] c,
                           input bit v, input bit last);
    char_item_t it;
    it.string_sel = sel;
    it.char_code = c;
    it.char_valid = v;
    it.end_of_pair = last;
    pending_chars.push_back(it);
  endtask

  // well-formed pair: related strings, last item may or may not carry a char
  task automatic push_pair(input int unsigned la, input int unsigned lb,
                           input int unsigned alphabet);
    logic [CHAR_W-1:0] a [];
    a = new[la];
    for (int i = 0; i < la; i++)
      a[i] = (alphabet == 0) ? CHAR_W'($urandom) : CHAR_W'(8'h2d + $urandom_range(0, alphabet));
    for (int i = 0; i < la; i++) push_char(0, a[i], 1, 0);
    for (int j = 0; j < lb; j++) begin
      if (j < la && $urandom_range(0, 3) != 0)
        push_char(1, a[j], 1, 0);
      else if (j + 1 < la && $urandom_range(0, 1) == 0)
        push_char(1, a[j + 1], 1, 0);
      else
        push_char(1, CHAR_W'(8'h2d + $urandom_range(0, alphabet + 3)), 1, 0);
    end
    if ($urandom_range(0, 1) == 0) push_char(0, 8'h2f, 0, 1);
    else push_char($urandom_range(0, 1), 8'h2f, 1, 1);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DAT_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_PREFIX_WEIGHT: pw = WGT_W'(val);
      CFG_PREFIX_LIMIT:  plim_reg = PFX_W'(val);
      CFG_BONUS_CHAR:    bchar = CHAR_W'(val);
      CFG_BONUS_WEIGHT:  bw = WGT_W'(val);
      default: ;
    endcase
  endtask

  // let every queued char and score drain, then cover the scoring latency
  task automatic drain();
    while (pending_chars.size() > 0 || expected_scores.size() > 0) @(posedge clk);
    repeat (3 * MAX_LEN + 60) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned pairs);
    int unsigned k;
    for (int p = 0; p < pairs; p++) begin
      k = $urandom_range(0, 19);
      if (k < 14)
        push_pair($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 6));
      else if (k < 16)
        push_pair($urandom_range(0, 70), $urandom_range(0, 70), $urandom_range(0, 1) * 250);
      else begin
        // noise: stray invalid items and random fields
        repeat ($urandom_range(1, 8))
          push_char($urandom_range(0, 1), CHAR_W'($urandom), $urandom_range(0, 1), 0);
        push_char($urandom_range(0, 1), CHAR_W'($urandom), $urandom_range(0, 1), 1);
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_PREFIX_WEIGHT;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.string_sel = 0;
    in_ch.char_code = '0;
    in_ch.char_valid = 0;
    in_ch.end_of_pair = 0;
    out_ch.ready = 0;
    len_a = 0;
    len_b = 0;
    pw = PW_RESET;
    plim_reg = PL_RESET;
    bchar = BCH_RESET;
    bw = BW_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: empty pair, identical, slash bonus, single chars, extremes
    push_char(0, 8'h00, 0, 1);
    push_char(0, 8'h61, 1, 0);
    push_char(1, 8'h61, 1, 1);
    push_char(0, 8'h61, 1, 0);
    push_char(0, 8'h2f, 1, 0);
    push_char(0, 8'h62, 1, 0);
    push_char(0, 8'h2f, 1, 0);
    push_char(1, 8'h61, 1, 0);
    push_char(1, 8'h2f, 1, 0);
    push_char(1, 8'h62, 1, 0);
    push_char(1, 8'h2f, 1, 0);
    push_char(0, 8'h00, 0, 1);
    push_char(0, 8'hff, 1, 0);
    push_char(1, 8'h00, 1, 1);
    push_char(0, 8'h6d, 0, 0);          // invalid item is ignored
    push_char(0, 8'h6d, 1, 0);
    push_char(0, 8'h61, 1, 0);
    push_char(1, 8'h61, 1, 0);
    push_char(1, 8'h6d, 1, 1);          // swapped pair
    repeat (66) push_char(0, 8'h78, 1, 0); // overflow drops bytes
    push_char(1, 8'h78, 1, 1);
    drain();

    // register extremes, including saturation of boost and bonus
    write_reg(CFG_PREFIX_WEIGHT, 16384);
    write_reg(CFG_PREFIX_LIMIT, 8);
    write_reg(CFG_BONUS_CHAR, 8'h2f);
    write_reg(CFG_BONUS_WEIGHT, 16384);
    random_phase(RANDOM_PAIRS / 4);
    drain();

    write_reg(CFG_PREFIX_WEIGHT, 0);
    write_reg(CFG_PREFIX_LIMIT, 0);
    write_reg(CFG_BONUS_CHAR, 8'hff);
    write_reg(CFG_BONUS_WEIGHT, 0);
    gaps_on = 0;
    random_phase(RANDOM_PAIRS / 4);
    drain();
    gaps_on = 1;

    write_reg(CFG_PREFIX_WEIGHT, 32767);
    write_reg(CFG_PREFIX_LIMIT, 15);
    write_reg(CFG_BONUS_CHAR, 8'h30);
    write_reg(CFG_BONUS_WEIGHT, 32767);
    // long receiver stall while the sender keeps offering pairs
    long_hold = 1;
    random_phase(RANDOM_PAIRS / 4);
    drain();
    long_hold = 0;

    write_reg(CFG_PREFIX_WEIGHT, $urandom_range(0, 16384));
    write_reg(CFG_PREFIX_LIMIT, $urandom_range(0, 8));
    write_reg(CFG_BONUS_CHAR, 8'h2d + $urandom_range(0, 4));
    write_reg(CFG_BONUS_WEIGHT, $urandom_range(0, 16384));
    random_phase(RANDOM_PAIRS / 4);
    drain();

    $display("covered %0d char transfers and %0d scores over five register settings",
             chars_sent, scores_seen);
    if (errors == 0) begin
      $display("jaro_winkler_similarity_core_test: PASS");
    end else begin
      $display("jaro_winkler_similarity_core_test: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/jws_pkg.sv
rtl/jws_if.sv
rtl/jws_cell.sv
rtl/jaro_winkler_similarity_core.sv
rtl/jws_checker.sv
tb/jaro_winkler_similarity_core_test.sv
